// ----- rtl/core/iplc_pkg.sv -----
package iplc_pkg;

	// Field widths
	localparam int FMT_W   = 4;
	localparam int DIM_W   = 14;
	localparam int IDX_W   = 2;
	localparam int BPP_W   = 3;
	localparam int PITCH_W = 16;
	localparam int SIZE_W  = 29;
	localparam int OFF_W   = 30;
	localparam int CFG_W   = 13;
	localparam int PROD_W  = 16;
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;

	// Register indexes (byte address bit 2)
	localparam logic REG_ROW_ALIGN    = 1'b0;
	localparam logic REG_HEIGHT_ALIGN = 1'b1;

	// Pixel format codes
	typedef enum logic [FMT_W-1:0] {
		FMT_GRAY8    = 4'd0,
		FMT_YUV420   = 4'd1,
		FMT_NV12     = 4'd2,
		FMT_NV21     = 4'd3,
		FMT_RGBA0    = 4'd4,
		FMT_RGBA1    = 4'd5,
		FMT_RGBA2    = 4'd6,
		FMT_RGBA3    = 4'd7,
		FMT_RGB      = 4'd8,
		FMT_BGR      = 4'd9,
		FMT_ARGB1555 = 4'd10
	} fmt_code_t;

	typedef struct packed {
		logic [FMT_W-1:0] pixel_format;
		logic [DIM_W-1:0] frame_width;
		logic [DIM_W-1:0] frame_height;
	} req_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]   plane_index;
		logic [IDX_W-1:0]   plane_count;
		logic [DIM_W-1:0]   plane_width;
		logic [DIM_W-1:0]   plane_height;
		logic [BPP_W-1:0]   pixel_bytes;
		logic [PITCH_W-1:0] row_pitch;
		logic [SIZE_W-1:0]  plane_bytes;
		logic [OFF_W-1:0]   plane_offset;
		logic               bad_format;
		logic               last_plane;
	} rsp_item_t;

	// Decoded format properties
	typedef struct packed {
		logic             bad;
		logic [IDX_W-1:0] planes;
		logic [BPP_W-1:0] bpp;
		logic             half_w;
	} fmt_info_t;

	// Per-plane metadata that rides alongside the rounding pipeline
	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [IDX_W-1:0] cnt;
		logic [DIM_W-1:0] pw;
		logic [DIM_W-1:0] ph;
		logic [BPP_W-1:0] bpp;
		logic             bad;
		logic             last;
	} plane_meta_t;

	function automatic fmt_info_t decode_fmt(input logic [FMT_W-1:0] code);
		fmt_info_t f;
		f = '{bad: 1'b0, planes: 2'd1, bpp: 3'd1, half_w: 1'b0};
		unique case (code)
			FMT_GRAY8: ;
			FMT_YUV420: begin
				f.planes = 2'd3;
				f.half_w = 1'b1;
			end
			FMT_NV12, FMT_NV21: f.planes = 2'd2;
			FMT_RGBA0, FMT_RGBA1, FMT_RGBA2, FMT_RGBA3: f.bpp = 3'd4;
			FMT_RGB, FMT_BGR: f.bpp = 3'd3;
			FMT_ARGB1555: f.bpp = 3'd2;
			default: f = '{bad: 1'b1, planes: 2'd1, bpp: 3'd0, half_w: 1'b0};
		endcase
		return f;
	endfunction

endpackage

// ----- rtl/core/image_plane_layout_calc.sv -----
// Channel | Direction | Handshake          | Payload
// req     | in        | req_valid/req_stall | iplc_pkg::req_item_t
// rsp     | out       | rsp_valid/rsp_stall | iplc_pkg::rsp_item_t
// cfg     | in        | APB psel/penable    | row_align, height_align
//
// One item yields one to three results, one result per cycle while rsp is
// not stalled; the plane sequencer sets the rate and takes the next item
// as it issues the last result of the current one. Each result then passes
// stage 1, the bitwise remainder stages and final add, stage 2 and the output register.
// arst_n clears valid bits, the sequencer and the alignment registers (to 1).
// A stall on rsp freezes the whole pipeline; nothing is lost or repeated.
module image_plane_layout_calc #(
	parameter int MAX_DIMENSION = 8192,
	parameter int MAX_ALIGN     = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  iplc_pkg::req_item_t           req,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output iplc_pkg::rsp_item_t           rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [iplc_pkg::ADDR_W-1:0]   paddr,
	input  logic [iplc_pkg::DATA_W-1:0]   pwdata,
	output logic [iplc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	localparam int AW    = (MAX_ALIGN > 1) ? $clog2(MAX_ALIGN + 1) : 1;
	localparam int VAL_W = (AW > iplc_pkg::PROD_W) ? AW : iplc_pkg::PROD_W;
	localparam int LAT   = VAL_W + 1;
	localparam int DW    = iplc_pkg::DIM_W;

	// Config registers
	logic [iplc_pkg::CFG_W-1:0] row_align_q, height_align_q;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_align_q    <= iplc_pkg::CFG_W'(1);
			height_align_q <= iplc_pkg::CFG_W'(1);
		end else if (cfg_wr) begin
			if (paddr[2] == iplc_pkg::REG_ROW_ALIGN) begin
				row_align_q <= pwdata[iplc_pkg::CFG_W-1:0];
			end else begin
				height_align_q <= pwdata[iplc_pkg::CFG_W-1:0];
			end
		end
	end

	assign prdata = (paddr[2] == iplc_pkg::REG_ROW_ALIGN)
		? iplc_pkg::DATA_W'(row_align_q) : iplc_pkg::DATA_W'(height_align_q);

	// Clamped alignments
	function automatic logic [AW-1:0] clamp_align(input logic [iplc_pkg::CFG_W-1:0] a);
		logic [AW-1:0] r;
		if (a == '0) r = AW'(1);
		else if (32'(a) > 32'(MAX_ALIGN)) r = AW'(MAX_ALIGN);
		else r = AW'(a);
		return r;
	endfunction

	function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] d);
		logic [DW-1:0] r;
		if (32'(d) > 32'(MAX_DIMENSION)) r = DW'(MAX_DIMENSION);
		else r = d;
		return r;
	endfunction

	logic [AW-1:0] aw, ah;
	assign aw = clamp_align(row_align_q);
	assign ah = clamp_align(height_align_q);

	// Global advance: output register empty or being taken
	logic adv;
	logic v_out_q;
	assign adv = !v_out_q || !rsp_stall;

	// Plane sequencer
	iplc_pkg::fmt_info_t seq_info_q;
	logic [DW-1:0] seq_w_q, seq_h_q;
	logic [iplc_pkg::IDX_W-1:0] seq_idx_q;
	logic busy_q, issue_last, take;

	assign issue_last = busy_q
		&& (seq_info_q.bad || (seq_idx_q == seq_info_q.planes - 2'd1));
	assign req_stall = !(adv && (!busy_q || issue_last));
	assign take = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			seq_idx_q <= '0;
		end else if (adv) begin
			if (take) begin
				busy_q    <= 1'b1;
				seq_idx_q <= '0;
			end else if (busy_q) begin
				busy_q    <= !issue_last;
				seq_idx_q <= seq_idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			seq_info_q <= iplc_pkg::decode_fmt(req.pixel_format);
			seq_w_q    <= clamp_dim(req.frame_width);
			seq_h_q    <= clamp_dim(req.frame_height);
		end
	end

	// Stage 1: plane dimensions and row bytes
	iplc_pkg::plane_meta_t meta_c, meta_s1;
	logic v_s1;
	logic [iplc_pkg::PROD_W-1:0] prod_s1;

	always_comb begin
		meta_c.idx  = seq_info_q.bad ? '0 : seq_idx_q;
		meta_c.cnt  = seq_info_q.bad ? '0 : seq_info_q.planes;
		meta_c.bpp  = seq_info_q.bpp;
		meta_c.bad  = seq_info_q.bad;
		meta_c.last = issue_last;
		if (seq_info_q.bad) begin
			meta_c.pw = '0;
			meta_c.ph = '0;
		end else begin
			meta_c.pw = (seq_idx_q != '0 && seq_info_q.half_w) ? (seq_w_q >> 1) : seq_w_q;
			meta_c.ph = (seq_idx_q != '0) ? (seq_h_q >> 1) : seq_h_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= busy_q;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s1 <= meta_c;
			prod_s1 <= iplc_pkg::PROD_W'(meta_c.pw) * iplc_pkg::PROD_W'(meta_c.bpp);
		end
	end

	// Rounding pipelines for pitch and height
	logic [VAL_W:0] pitch_r, height_r;

	iplc_round_up #(.W(VAL_W), .AW(AW)) u_pitch (
		.clk (clk),
		.en  (adv),
		.val (VAL_W'(prod_s1)),
		.aln (aw),
		.res (pitch_r)
	);

	iplc_round_up #(.W(VAL_W), .AW(AW)) u_height (
		.clk (clk),
		.en  (adv),
		.val (VAL_W'(meta_s1.ph)),
		.aln (ah),
		.res (height_r)
	);

	// Metadata delay line matching the rounders
	iplc_pkg::plane_meta_t meta_dly_q [0:LAT-1];
	logic [LAT-1:0] v_dly_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_dly_q <= '0;
		else if (adv) v_dly_q <= {v_dly_q[LAT-2:0], v_s1};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_dly_q[0] <= meta_s1;
			for (int k = 1; k < LAT; k++) meta_dly_q[k] <= meta_dly_q[k-1];
		end
	end

	// Stage 2: plane size
	iplc_pkg::plane_meta_t meta_s2;
	logic v_s2;
	logic [iplc_pkg::PITCH_W-1:0] pitch_s2;
	logic [2*VAL_W+1:0] size_full;
	logic [iplc_pkg::OFF_W-1:0] size_s2;

	assign size_full = (2*VAL_W+2)'(pitch_r) * (2*VAL_W+2)'(height_r);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_dly_q[LAT-1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s2  <= meta_dly_q[LAT-1];
			pitch_s2 <= pitch_r[iplc_pkg::PITCH_W-1:0];
			size_s2  <= size_full[iplc_pkg::OFF_W-1:0];
		end
	end

	// Stage 3: offset accumulation and output register
	logic [iplc_pkg::OFF_W-1:0] acc_q, off_c;
	assign off_c = (meta_s2.idx == '0) ? '0 : acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out_q <= 1'b0;
			acc_q   <= '0;
		end else if (adv) begin
			v_out_q <= v_s2;
			if (v_s2) acc_q <= off_c + size_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp.plane_index  <= meta_s2.idx;
			rsp.plane_count  <= meta_s2.cnt;
			rsp.plane_width  <= meta_s2.pw;
			rsp.plane_height <= meta_s2.ph;
			rsp.pixel_bytes  <= meta_s2.bpp;
			rsp.row_pitch    <= pitch_s2;
			rsp.plane_bytes  <= size_s2[iplc_pkg::SIZE_W-1:0];
			rsp.plane_offset <= off_c;
			rsp.bad_format   <= meta_s2.bad;
			rsp.last_plane   <= meta_s2.last;
		end
	end

	assign rsp_valid = v_out_q;

	// Checks
	a_bad_is_single: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.bad_format |-> rsp.last_plane && rsp.plane_count == '0)
		else $error("bad format result not a lone zero result");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.bad_format |-> rsp.plane_index < rsp.plane_count)
		else $error("plane index beyond plane count");

	a_last_matches: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.bad_format |->
			(rsp.last_plane == (rsp.plane_index + 2'd1 == rsp.plane_count)))
		else $error("last plane flag wrong");

	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> $stable(v_s1) && $stable(v_s2) && $stable(busy_q))
		else $error("pipeline moved while stalled");

endmodule

// ----- rtl/core/iplc_round_up.sv -----
// Pipelined round-up to a multiple: one restoring remainder bit per stage,
// then a final add.
module iplc_round_up #(
	parameter int W  = 17,
	parameter int AW = 13
) (
	input  logic          clk,
	input  logic          en,
	input  logic [W-1:0]  val,
	input  logic [AW-1:0] aln,
	output logic [W:0]    res
);

	logic [W-1:0]  val_s [0:W];
	logic [AW-1:0] aln_s [0:W];
	logic [AW-1:0] rem_s [0:W];
	logic [W:0]    res_q;

	assign val_s[0] = val;
	assign aln_s[0] = aln;
	assign rem_s[0] = '0;

	// One remainder bit per stage, MSB first
	for (genvar k = 0; k < W; k++) begin : g_bit
		logic [AW:0] trial;
		logic [AW:0] diff;
		assign trial = {rem_s[k], val_s[k][W-1-k]};
		assign diff  = trial - {1'b0, aln_s[k]};
		always_ff @(posedge clk) begin
			if (en) begin
				val_s[k+1] <= val_s[k];
				aln_s[k+1] <= aln_s[k];
				rem_s[k+1] <= (trial >= {1'b0, aln_s[k]}) ? AW'(diff) : AW'(trial);
			end
		end
	end

	// Add the gap to the next multiple
	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= (rem_s[W] == '0) ? {1'b0, val_s[W]}
				: ({1'b0, val_s[W]} + (W+1)'(aln_s[W] - rem_s[W]));
		end
	end

	assign res = res_q;

endmodule
